### hw/rtl/bffa_pkg.sv
// Shared types, sizes and helpers for the bitmap first-free allocator.
// No dependencies; every other file in hw/rtl imports this package.
package bffa_pkg;

    localparam int BLOCK_BYTES     = 4096;
    localparam int MAX_BLOCKS      = 8;
    localparam int BITS_PER_BYTE   = 8;
    localparam int WORD_BYTES      = 8;
    localparam int WORD_BITS       = WORD_BYTES * BITS_PER_BYTE;
    localparam int WORDS_PER_BLOCK = BLOCK_BYTES / WORD_BYTES;
    localparam int STORE_BYTES     = MAX_BLOCKS * BLOCK_BYTES;
    localparam int STORE_WORDS     = STORE_BYTES / WORD_BYTES;
    localparam int WADDR_W         = $clog2(STORE_WORDS);
    localparam int WIB_W           = $clog2(WORDS_PER_BLOCK);
    localparam int LANE_W          = $clog2(WORD_BYTES);
    localparam int BIDX_W          = $clog2(WORD_BITS);

    localparam int CFG_W           = 4;
    localparam int BADDR_W         = 15;
    localparam int BYTE_W          = 8;
    localparam int BLK_W           = 3;
    localparam int BIT_W           = 15;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_ALLOC = 1'b1;

    localparam logic REG_BLOCKS_IN_USE = 1'b0;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [WADDR_W-1:0]   t_waddr;

    typedef struct packed {
        logic   we;
        t_waddr waddr;
        t_word  wdata;
        logic   re;
        t_waddr raddr;
    } t_ram_req;

    typedef struct packed {
        logic              found;
        logic [BIDX_W-1:0] idx;
    } t_ffz;

    // Lowest zero bit of a bitmap word.
    function automatic t_ffz find_first_zero(t_word w);
        t_ffz r;
        r.found = 1'b0;
        r.idx   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                r.found = 1'b1;
                r.idx   = BIDX_W'(i);
            end
        end
        return r;
    endfunction

endpackage

### hw/rtl/bitmap_first_free_allocator_core.sv
// Bitmap first-free allocator: top level with the APB register and the bitmap RAM.
// Depends on bffa_pkg, bffa_bitmap_ram and bffa_ctrl.
//
// The free-space bitmap (8 blocks of 4096 bytes) sits in a RAM of 4096 words
// of 64 bits. After reset a clearing pass writes the whole RAM to zero, one
// word per cycle, and the input channel stays not-ready until it ends; the
// register port works during that time. A load transfer (kind 0) is a word
// read, then a merged write of the byte. An allocate transfer (kind 1) reads
// one 64-bit word per cycle from block 0 upward until a word with a zero bit
// appears, then claims that bit; when nothing is free it scans 512 words per
// block in use. One item is in work at a time; a result waits in the output
// register while the next transfer is taken.
// blocks_in_use (register 0, reset 1) above 8 counts as 8; zero gives found 0.
module bitmap_first_free_allocator_core
    import bffa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,

    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_kind,
    input  logic [BADDR_W-1:0] i_byte_address,
    input  logic [BYTE_W-1:0]  i_byte_value,

    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_found,
    output logic [BLK_W-1:0]   o_block_number,
    output logic [BIT_W-1:0]   o_bit_index
);

    logic [CFG_W-1:0] r_blocks_in_use;
    logic             w_reg_sel;
    t_ram_req         w_ram_req;
    t_word            w_rdata;

    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[PADDR_W-1] == REG_BLOCKS_IN_USE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocks_in_use <= CFG_W'(1);
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_blocks_in_use <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = w_reg_sel ? PDATA_W'(r_blocks_in_use) : '0;

    bffa_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_blocks_in_use (r_blocks_in_use),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_byte_address  (i_byte_address),
        .i_byte_value    (i_byte_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_found         (o_found),
        .o_block_number  (o_block_number),
        .o_bit_index     (o_bit_index),
        .o_ram_req       (w_ram_req),
        .i_rdata         (w_rdata)
    );

    bffa_bitmap_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (w_ram_req),
        .o_rdata (w_rdata)
    );

endmodule

### hw/rtl/bffa_bitmap_ram.sv
// Bitmap storage: one write port, one read port, registered read data.
// Depends on bffa_pkg for word and address types.
module bffa_bitmap_ram
    import bffa_pkg::*;
(
    input  logic     i_clk,
    input  t_ram_req i_req,
    output t_word    o_rdata
);

    t_word r_mem [STORE_WORDS];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/bffa_ctrl.sv
// Sequencer: clearing pass, byte loads (read-merge-write) and the word-by-word
// free-bit scan with claim write-back. Holds the result register.
// Depends on bffa_pkg.
module bffa_ctrl
    import bffa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [CFG_W-1:0]   i_blocks_in_use,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_kind,
    input  logic [BADDR_W-1:0] i_byte_address,
    input  logic [BYTE_W-1:0]  i_byte_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_found,
    output logic [BLK_W-1:0]   o_block_number,
    output logic [BIT_W-1:0]   o_bit_index,
    output t_ram_req           o_ram_req,
    input  t_word              i_rdata
);

    localparam logic [2:0] ST_CLEAR   = 3'd0;
    localparam logic [2:0] ST_IDLE    = 3'd1;
    localparam logic [2:0] ST_LOAD_RD = 3'd2;
    localparam logic [2:0] ST_LOAD_WR = 3'd3;
    localparam logic [2:0] ST_SCAN    = 3'd4;
    localparam logic [2:0] ST_RESULT  = 3'd5;

    logic [2:0]          r_state,     n_state;
    t_waddr              r_clr_addr,  n_clr_addr;
    logic [WADDR_W:0]    r_raddr,     n_raddr;
    logic                r_pend,      n_pend;
    t_waddr              r_chk,       n_chk;
    logic [WADDR_W:0]    r_end,       n_end;
    logic                r_out_valid, n_out_valid;

    t_waddr              r_hit_addr,  n_hit_addr;
    t_word               r_hit_word,  n_hit_word;
    logic                r_found,     n_found;
    logic [BIDX_W-1:0]   r_idx,       n_idx;
    logic [LANE_W-1:0]   r_lane,      n_lane;
    logic [BYTE_W-1:0]   r_byte,      n_byte;
    logic                r_out_found, n_out_found;
    logic [BLK_W-1:0]    r_out_block, n_out_block;
    logic [BIT_W-1:0]    r_out_bit,   n_out_bit;

    logic [CFG_W-1:0]    w_limit;
    logic [WADDR_W:0]    w_scan_end;
    t_ffz                w_ffz;
    t_word               w_merged;
    t_ram_req            w_req;

    assign w_limit    = (i_blocks_in_use > CFG_W'(MAX_BLOCKS)) ? CFG_W'(MAX_BLOCKS)
                                                               : i_blocks_in_use;
    assign w_scan_end = (WADDR_W+1)'(w_limit) * (WADDR_W+1)'(WORDS_PER_BLOCK);
    assign w_ffz      = find_first_zero(i_rdata);

    always_comb begin
        w_merged = i_rdata;
        w_merged[r_lane*BITS_PER_BYTE +: BITS_PER_BYTE] = r_byte;
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_raddr     = r_raddr;
        n_pend      = r_pend;
        n_chk       = r_chk;
        n_end       = r_end;
        n_hit_addr  = r_hit_addr;
        n_hit_word  = r_hit_word;
        n_found     = r_found;
        n_idx       = r_idx;
        n_lane      = r_lane;
        n_byte      = r_byte;
        n_out_found = r_out_found;
        n_out_block = r_out_block;
        n_out_bit   = r_out_bit;
        n_out_valid = r_out_valid;
        w_req       = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_CLEAR: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_clr_addr;
                w_req.wdata = '0;
                n_clr_addr  = r_clr_addr + 1'b1;
                if (r_clr_addr == WADDR_W'(STORE_WORDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_kind == KIND_LOAD) begin
                        // loads beyond the store are dropped
                        if (32'(i_byte_address) < 32'(STORE_BYTES)) begin
                            n_hit_addr = WADDR_W'(i_byte_address >> LANE_W);
                            n_lane     = i_byte_address[LANE_W-1:0];
                            n_byte     = i_byte_value;
                            n_state    = ST_LOAD_RD;
                        end
                    end else begin
                        n_raddr = '0;
                        n_pend  = 1'b0;
                        n_end   = w_scan_end;
                        if (w_scan_end == '0) begin
                            n_found    = 1'b0;
                            n_idx      = '0;
                            n_hit_addr = '0;
                            n_state    = ST_RESULT;
                        end else begin
                            n_state = ST_SCAN;
                        end
                    end
                end
            end
            ST_LOAD_RD: begin
                w_req.re    = 1'b1;
                w_req.raddr = r_hit_addr;
                n_state     = ST_LOAD_WR;
            end
            ST_LOAD_WR: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_hit_addr;
                w_req.wdata = w_merged;
                n_state     = ST_IDLE;
            end
            ST_SCAN: begin
                // one read in flight; r_chk names the word now on i_rdata
                if (r_raddr < r_end) begin
                    w_req.re    = 1'b1;
                    w_req.raddr = r_raddr[WADDR_W-1:0];
                    n_raddr     = r_raddr + 1'b1;
                    n_pend      = 1'b1;
                    n_chk       = r_raddr[WADDR_W-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (w_ffz.found) begin
                        n_found    = 1'b1;
                        n_idx      = w_ffz.idx;
                        n_hit_addr = r_chk;
                        n_hit_word = i_rdata;
                        n_state    = ST_RESULT;
                    end else if ({1'b0, r_chk} + 1'b1 == r_end) begin
                        n_found    = 1'b0;
                        n_idx      = '0;
                        n_hit_addr = '0;
                        n_state    = ST_RESULT;
                    end
                end
            end
            ST_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    if (r_found) begin
                        w_req.we    = 1'b1;
                        w_req.waddr = r_hit_addr;
                        w_req.wdata = r_hit_word | (WORD_BITS'(1) << r_idx);
                    end
                    n_out_valid = 1'b1;
                    n_out_found = r_found;
                    n_out_block = r_found ? BLK_W'(r_hit_addr >> WIB_W) : '0;
                    n_out_bit   = r_found ? BIT_W'({r_hit_addr[WIB_W-1:0], r_idx}) : '0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_raddr     <= '0;
            r_pend      <= 1'b0;
            r_chk       <= '0;
            r_end       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_raddr     <= n_raddr;
            r_pend      <= n_pend;
            r_chk       <= n_chk;
            r_end       <= n_end;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit_addr  <= n_hit_addr;
        r_hit_word  <= n_hit_word;
        r_found     <= n_found;
        r_idx       <= n_idx;
        r_lane      <= n_lane;
        r_byte      <= n_byte;
        r_out_found <= n_out_found;
        r_out_block <= n_out_block;
        r_out_bit   <= n_out_bit;
    end

    assign o_in_ready     = (r_state == ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_found        = r_out_found;
    assign o_block_number = r_out_block;
    assign o_bit_index    = r_out_bit;
    assign o_ram_req      = w_req;

endmodule
